// ----- hw/rtl/spte_pkg.sv -----
// Shared types, codes and saturating arithmetic for the sparse polynomial term engine.
// No dependencies; every other file imports this package.
`default_nettype none
package spte_pkg;

  localparam int COEF_W      = 32;
  localparam int EXP_W       = 15;
  localparam int PEXP_W      = 16;
  localparam int MAX_RESULTS = 64;
  localparam int NRES_W      = 7;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_ATTACH = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_SCALE  = 3'd3,
    MODE_LEAD   = 3'd4,
    MODE_ADD    = 3'd5,
    MODE_MUL    = 3'd6,
    MODE_NOP    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_SAT       = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ATT_RD,
    S_ATT_CHK,
    S_REM_RD,
    S_REM_CHK,
    S_REM_LRD,
    S_REM_MOVE,
    S_SCL_RD,
    S_SCL_MUL,
    S_SCL_WR,
    S_LQ_RD,
    S_LQ_CHK,
    S_ADD_CLR,
    S_ADD_ARD,
    S_ADD_ALD,
    S_ADD_BRD,
    S_ADD_BCHK,
    S_ADD_URD,
    S_ADD_UCHK,
    S_MUL_RD,
    S_MUL_MUL,
    S_MUL_FEED,
    S_MUL_DRAIN,
    S_MUL_OUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     valid;
    logic                     sat;
    logic [PEXP_W-1:0]        expo;
    logic signed [COEF_W-1:0] coef;
  } prod_item_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } chain_ctl_t;

  // {saturated, value}
  function automatic logic [COEF_W:0] sat_add(input logic signed [COEF_W-1:0] a,
                                              input logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return {1'b1, s[COEF_W], {(COEF_W-1){~s[COEF_W]}}};
    end
    return {1'b0, s[COEF_W-1:0]};
  endfunction

  function automatic logic [COEF_W:0] sat_clamp(input logic signed [63:0] v);
    logic hi_same;
    hi_same = (v[63:COEF_W-1] == {(65-COEF_W){v[63]}});
    if (!hi_same) begin
      return {1'b1, v[63], {(COEF_W-1){~v[63]}}};
    end
    return {1'b0, v[COEF_W-1:0]};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sparse_polynomial_term_engine_unit.sv -----
// Sparse polynomial term engine, top level: term tables A and B in memories, a
// sequencer over one read port per table, and the spte_chain product store.
// Uses spte_pkg and spte_chain.
//
// A request is taken when start is high and busy is low; busy stays high until the
// last result has been shown. Results appear one per cycle at most, each for one
// cycle with strobe high, and cannot be held off; last marks the final one.
// The single read port of each table sets the pace: attach, remove, scale, leading
// query and add scan their entries one at a time; multiply forms each product pair,
// then waits for the chain to settle, then emits the product terms.
`default_nettype none
module sparse_polynomial_term_engine_unit #(
  parameter int TERMS         = 32,
  parameter int PRODUCT_TERMS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         mode,
  input  logic               poly_select,
  input  logic signed [23:0] term_coefficient,
  input  logic [14:0]        term_exponent,
  output logic               busy,
  output logic               strobe,
  output logic signed [31:0] out_coefficient,
  output logic [15:0]        out_exponent,
  output logic               last,
  output logic [2:0]         status
);
  import spte_pkg::*;

  localparam int IW = $clog2(TERMS);
  localparam int CW = $clog2(TERMS + 1);
  localparam int DW = $clog2(PRODUCT_TERMS + 2);

  // table memories
  logic signed [COEF_W-1:0] a_coef [TERMS];
  logic [EXP_W-1:0]         a_exp  [TERMS];
  logic signed [COEF_W-1:0] b_coef [TERMS];
  logic [EXP_W-1:0]         b_exp  [TERMS];
  logic                     m_mem  [TERMS];

  logic signed [COEF_W-1:0] a_rd, b_rd;
  logic [EXP_W-1:0]         a_erd, b_erd;
  logic                     m_rd;

  logic [IW-1:0]            a_raddr, b_raddr, a_waddr, b_waddr, m_waddr;
  logic                     a_we, b_we, m_we, m_wdata;
  logic signed [COEF_W-1:0] a_wcoef, b_wcoef;
  logic [EXP_W-1:0]         a_wexp, b_wexp;

  // control
  state_t          state, state_next;
  logic [CW-1:0]   a_count, a_count_next, b_count, b_count_next;
  logic [NRES_W-1:0] nprod, nprod_next;
  logic            ob_valid, ob_valid_next;
  logic            strobe_next;

  // payload
  logic                     sel, sel_next;
  logic signed [23:0]       tc, tc_next;
  logic [EXP_W-1:0]         te, te_next;
  logic [CW-1:0]            i, i_next, j, j_next;
  logic signed [COEF_W-1:0] acc, acc_next;
  logic [PEXP_W-1:0]        aexp, aexp_next;
  logic                     acc_sat, acc_sat_next;
  logic signed [63:0]       prod, prod_next;
  logic [PEXP_W-1:0]        pexp, pexp_next;
  logic                     dropped, dropped_next;
  logic [DW-1:0]            dcnt, dcnt_next;
  logic signed [COEF_W-1:0] ob_coef, ob_coef_next;
  logic [PEXP_W-1:0]        ob_exp, ob_exp_next;
  status_t                  ob_st, ob_st_next;
  logic signed [COEF_W-1:0] out_coefficient_next;
  logic [PEXP_W-1:0]        out_exponent_next;
  logic                     last_next;
  status_t                  status_q, status_next;

  // chain
  chain_ctl_t ctl;
  prod_item_t feed, head;
  logic       drop;

  spte_chain #(.DEPTH(PRODUCT_TERMS)) u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .feed (feed),
    .head (head),
    .drop (drop)
  );

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_coef[a_waddr] <= a_wcoef;
      a_exp[a_waddr]  <= a_wexp;
    end
    if (b_we) begin
      b_coef[b_waddr] <= b_wcoef;
      b_exp[b_waddr]  <= b_wexp;
    end
    if (m_we) begin
      m_mem[m_waddr] <= m_wdata;
    end
    a_rd  <= a_coef[a_raddr];
    a_erd <= a_exp[a_raddr];
    b_rd  <= b_coef[b_raddr];
    b_erd <= b_exp[b_raddr];
    m_rd  <= m_mem[b_raddr];
  end

  logic [CW-1:0]            cnt;
  logic signed [COEF_W-1:0] t_rd;
  logic [EXP_W-1:0]         t_erd;
  logic [CW-1:0]            jm1, cntm1;
  logic [COEF_W:0]          add_r, clamp_r;
  logic                     pv;
  logic signed [COEF_W-1:0] pc;
  logic [PEXP_W-1:0]        pe;
  status_t                  ps;
  logic                     tw_en;
  logic [IW-1:0]            tw_addr, tr_addr;
  logic signed [COEF_W-1:0] tw_coef;
  logic [EXP_W-1:0]         tw_exp;

  assign cnt   = sel ? b_count : a_count;
  assign t_rd  = sel ? b_rd : a_rd;
  assign t_erd = sel ? b_erd : a_erd;
  assign jm1   = j - CW'(1);
  assign cntm1 = cnt - CW'(1);
  assign busy  = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    a_count_next  = a_count;
    b_count_next  = b_count;
    nprod_next    = nprod;
    ob_valid_next = ob_valid;
    sel_next      = sel;
    tc_next       = tc;
    te_next       = te;
    i_next        = i;
    j_next        = j;
    acc_next      = acc;
    aexp_next     = aexp;
    acc_sat_next  = acc_sat;
    prod_next     = prod;
    pexp_next     = pexp;
    dropped_next  = dropped | drop;
    dcnt_next     = dcnt;
    ob_coef_next  = ob_coef;
    ob_exp_next   = ob_exp;
    ob_st_next    = ob_st;
    strobe_next          = 1'b0;
    out_coefficient_next = '0;
    out_exponent_next    = '0;
    last_next            = 1'b0;
    status_next          = ST_OK;
    pv      = 1'b0;
    pc      = '0;
    pe      = '0;
    ps      = ST_OK;
    tw_en   = 1'b0;
    tr_addr = i[IW-1:0];
    tw_addr = i[IW-1:0];
    tw_coef = '0;
    tw_exp  = '0;
    a_raddr = i[IW-1:0];
    b_raddr = j[IW-1:0];
    m_we    = 1'b0;
    m_waddr = j[IW-1:0];
    m_wdata = 1'b0;
    ctl     = '0;
    feed    = '0;
    add_r   = sat_add(acc, b_rd);
    clamp_r = sat_clamp(prod);

    case (state)
      S_IDLE: begin
        if (start) begin
          sel_next     = poly_select;
          tc_next      = term_coefficient;
          te_next      = term_exponent;
          i_next       = '0;
          j_next       = '0;
          acc_sat_next = 1'b0;
          dropped_next = 1'b0;
          case (mode_t'(mode))
            MODE_CLEAR: begin
              if (poly_select) begin
                b_count_next = '0;
              end else begin
                a_count_next = '0;
              end
              pv = 1'b1;
              state_next = S_DONE;
            end
            MODE_ATTACH: state_next = S_ATT_RD;
            MODE_REMOVE: state_next = S_REM_RD;
            MODE_SCALE:  state_next = S_SCL_RD;
            MODE_LEAD:   state_next = S_LQ_RD;
            MODE_ADD:    state_next = S_ADD_CLR;
            MODE_MUL: begin
              ctl.clr    = 1'b1;
              state_next = S_MUL_RD;
            end
            default: begin
              pv = 1'b1;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_ATT_RD: begin
        if (i == cnt) begin
          pv = 1'b1;
          if (cnt == CW'(TERMS)) begin
            ps = ST_FULL;
          end else begin
            tw_en   = 1'b1;
            tw_addr = cnt[IW-1:0];
            tw_coef = COEF_W'(tc);
            tw_exp  = te;
            if (sel) begin
              b_count_next = cnt + CW'(1);
            end else begin
              a_count_next = cnt + CW'(1);
            end
          end
          state_next = S_DONE;
        end else begin
          state_next = S_ATT_CHK;
        end
      end
      S_ATT_CHK: begin
        if (t_erd == te) begin
          add_r   = sat_add(t_rd, COEF_W'(tc));
          tw_en   = 1'b1;
          tw_coef = add_r[COEF_W-1:0];
          tw_exp  = te;
          pv      = 1'b1;
          ps      = add_r[COEF_W] ? ST_SAT : ST_OK;
          state_next = S_DONE;
        end else begin
          i_next = i + CW'(1);
          state_next = S_ATT_RD;
        end
      end
      S_REM_RD: begin
        if (i == cnt) begin
          pv = 1'b1;
          ps = ST_NOT_FOUND;
          state_next = S_DONE;
        end else begin
          state_next = S_REM_CHK;
        end
      end
      S_REM_CHK: begin
        if (t_erd == te) begin
          state_next = S_REM_LRD;
        end else begin
          i_next = i + CW'(1);
          state_next = S_REM_RD;
        end
      end
      S_REM_LRD: begin
        tr_addr    = cntm1[IW-1:0];
        state_next = S_REM_MOVE;
      end
      S_REM_MOVE: begin
        tw_en   = 1'b1;
        tw_coef = t_rd;
        tw_exp  = t_erd;
        if (sel) begin
          b_count_next = cntm1;
        end else begin
          a_count_next = cntm1;
        end
        pv = 1'b1;
        state_next = S_DONE;
      end
      S_SCL_RD: begin
        if (i == cnt) begin
          pv = 1'b1;
          ps = acc_sat ? ST_SAT : ST_OK;
          state_next = S_DONE;
        end else begin
          state_next = S_SCL_MUL;
        end
      end
      S_SCL_MUL: begin
        prod_next  = 64'($signed(t_rd) * $signed(tc));
        state_next = S_SCL_WR;
      end
      S_SCL_WR: begin
        tw_en        = 1'b1;
        tw_coef      = clamp_r[COEF_W-1:0];
        tw_exp       = t_erd;
        acc_sat_next = acc_sat | clamp_r[COEF_W];
        i_next       = i + CW'(1);
        state_next   = S_SCL_RD;
      end
      S_LQ_RD: begin
        if (cnt == '0) begin
          pv = 1'b1;
          ps = ST_EMPTY;
          state_next = S_DONE;
        end else if (i == cnt) begin
          pv = 1'b1;
          pc = acc;
          pe = aexp;
          state_next = S_DONE;
        end else begin
          state_next = S_LQ_CHK;
        end
      end
      S_LQ_CHK: begin
        if (i == '0 || PEXP_W'(t_erd) > aexp) begin
          acc_next  = t_rd;
          aexp_next = PEXP_W'(t_erd);
        end
        i_next = i + CW'(1);
        state_next = S_LQ_RD;
      end
      S_ADD_CLR: begin
        if (j == b_count) begin
          i_next = '0;
          state_next = S_ADD_ARD;
        end else begin
          m_we    = 1'b1;
          m_wdata = 1'b0;
          j_next  = j + CW'(1);
        end
      end
      S_ADD_ARD: begin
        if (i == a_count) begin
          j_next = '0;
          state_next = S_ADD_URD;
        end else begin
          state_next = S_ADD_ALD;
        end
      end
      S_ADD_ALD: begin
        acc_next     = a_rd;
        aexp_next    = PEXP_W'(a_erd);
        acc_sat_next = 1'b0;
        j_next       = b_count;
        state_next   = S_ADD_BRD;
      end
      S_ADD_BRD: begin
        b_raddr = jm1[IW-1:0];
        if (j == '0) begin
          pv = 1'b1;
          pc = acc;
          pe = aexp;
          i_next = i + CW'(1);
          state_next = S_ADD_ARD;
        end else begin
          state_next = S_ADD_BCHK;
        end
      end
      S_ADD_BCHK: begin
        b_raddr = jm1[IW-1:0];
        if (!m_rd && PEXP_W'(b_erd) == aexp) begin
          m_we    = 1'b1;
          m_waddr = jm1[IW-1:0];
          m_wdata = 1'b1;
          pv = 1'b1;
          pc = add_r[COEF_W-1:0];
          pe = aexp;
          ps = add_r[COEF_W] ? ST_SAT : ST_OK;
          i_next = i + CW'(1);
          state_next = S_ADD_ARD;
        end else begin
          j_next = jm1;
          state_next = S_ADD_BRD;
        end
      end
      S_ADD_URD: begin
        if (j == b_count) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ADD_UCHK;
        end
      end
      S_ADD_UCHK: begin
        if (!m_rd) begin
          pv = 1'b1;
          pc = b_rd;
          pe = PEXP_W'(b_erd);
        end
        j_next = j + CW'(1);
        state_next = S_ADD_URD;
      end
      S_MUL_RD: begin
        dcnt_next = '0;
        if (i == a_count || b_count == '0) begin
          state_next = S_MUL_DRAIN;
        end else begin
          state_next = S_MUL_MUL;
        end
      end
      S_MUL_MUL: begin
        prod_next  = 64'($signed(a_rd) * $signed(b_rd));
        pexp_next  = PEXP_W'(a_erd) + PEXP_W'(b_erd);
        state_next = S_MUL_FEED;
      end
      S_MUL_FEED: begin
        feed.valid = 1'b1;
        feed.sat   = clamp_r[COEF_W];
        feed.expo  = pexp;
        feed.coef  = clamp_r[COEF_W-1:0];
        if (j + CW'(1) == b_count) begin
          j_next = '0;
          i_next = i + CW'(1);
        end else begin
          j_next = j + CW'(1);
        end
        state_next = S_MUL_RD;
      end
      S_MUL_DRAIN: begin
        dcnt_next = dcnt + DW'(1);
        if (dcnt == DW'(PRODUCT_TERMS + 1)) begin
          state_next = S_MUL_OUT;
        end
      end
      S_MUL_OUT: begin
        if (head.valid) begin
          ctl.shift = 1'b1;
          pv = 1'b1;
          pc = head.coef;
          pe = head.expo;
          ps = head.sat ? ST_SAT : ST_OK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
        if (ob_valid) begin
          out_coefficient_next = ob_coef;
          out_exponent_next    = ob_exp;
          status_next          = dropped ? ST_FULL : ob_st;
        end else begin
          status_next = dropped ? ST_FULL : ST_EMPTY;
        end
        ob_valid_next = 1'b0;
        nprod_next    = '0;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (state == S_LQ_CHK || state == S_LQ_RD || state == S_REM_LRD ||
        state == S_REM_MOVE || state == S_ATT_RD || state == S_ATT_CHK ||
        state == S_REM_RD || state == S_REM_CHK || state == S_SCL_RD ||
        state == S_SCL_MUL || state == S_SCL_WR) begin
      a_raddr = tr_addr;
      b_raddr = tr_addr;
    end

    if (pv && nprod < NRES_W'(MAX_RESULTS)) begin
      if (ob_valid) begin
        strobe_next          = 1'b1;
        out_coefficient_next = ob_coef;
        out_exponent_next    = ob_exp;
        status_next          = ob_st;
      end
      ob_valid_next = 1'b1;
      ob_coef_next  = pc;
      ob_exp_next   = pe;
      ob_st_next    = ps;
      nprod_next    = nprod + NRES_W'(1);
    end

    a_we    = tw_en && !sel;
    b_we    = tw_en && sel;
    a_waddr = tw_addr;
    b_waddr = tw_addr;
    a_wcoef = tw_coef;
    b_wcoef = tw_coef;
    a_wexp  = tw_exp;
    b_wexp  = tw_exp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      a_count  <= '0;
      b_count  <= '0;
      nprod    <= '0;
      ob_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      a_count  <= a_count_next;
      b_count  <= b_count_next;
      nprod    <= nprod_next;
      ob_valid <= ob_valid_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    sel             <= sel_next;
    tc              <= tc_next;
    te              <= te_next;
    i               <= i_next;
    j               <= j_next;
    acc             <= acc_next;
    aexp            <= aexp_next;
    acc_sat         <= acc_sat_next;
    prod            <= prod_next;
    pexp            <= pexp_next;
    dropped         <= dropped_next;
    dcnt            <= dcnt_next;
    ob_coef         <= ob_coef_next;
    ob_exp          <= ob_exp_next;
    ob_st           <= ob_st_next;
    out_coefficient <= out_coefficient_next;
    out_exponent    <= out_exponent_next;
    last            <= last_next;
    status_q        <= status_next;
  end

  assign status = status_q;

  a_busy_falls_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last)
    else $error("busy dropped without a final result");

  a_last_when_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final result shown while still busy");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not start work");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    a_count <= CW'(TERMS) && b_count <= CW'(TERMS))
    else $error("table count beyond capacity");

endmodule
`default_nettype wire

// ----- hw/rtl/spte_cell.sv -----
// One cell of the product accumulation chain: holds one product term, merges a
// passing term of equal exponent, captures when empty, else hands it on. Uses spte_pkg.
`default_nettype none
module spte_cell (
  input  logic                clk,
  input  logic                rst,
  input  spte_pkg::chain_ctl_t ctl,
  input  spte_pkg::prod_item_t in_item,
  input  spte_pkg::prod_item_t nxt_item,
  output spte_pkg::prod_item_t held,
  output spte_pkg::prod_item_t pass
);
  import spte_pkg::*;

  logic [COEF_W:0] sum;

  assign sum = sat_add(held.coef, in_item.coef);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      held.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else if (ctl.shift) begin
      held       <= nxt_item;
      pass.valid <= 1'b0;
    end else begin
      if (in_item.valid && held.valid && held.expo != in_item.expo) begin
        pass <= in_item;
      end else begin
        pass.valid <= 1'b0;
      end
      if (in_item.valid) begin
        if (held.valid && held.expo == in_item.expo) begin
          held.coef <= sum[COEF_W-1:0];
          held.sat  <= held.sat | in_item.sat | sum[COEF_W];
        end else if (!held.valid) begin
          held <= in_item;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/spte_chain.sv -----
// Product store as a row of spte_cell instances; terms enter at cell 0 and results
// shift out of cell 0. Uses spte_pkg and spte_cell.
`default_nettype none
module spte_chain #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spte_pkg::chain_ctl_t ctl,
  input  spte_pkg::prod_item_t feed,
  output spte_pkg::prod_item_t head,
  output logic                 drop
);
  import spte_pkg::*;

  prod_item_t held [DEPTH];
  prod_item_t pass [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    prod_item_t in_k;
    prod_item_t nxt_k;
    if (k == 0) begin : g_first
      assign in_k = feed;
    end else begin : g_mid
      assign in_k = pass[k-1];
    end
    if (k == DEPTH-1) begin : g_end
      assign nxt_k = '0;
    end else begin : g_inner
      assign nxt_k = held[k+1];
    end
    spte_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .in_item  (in_k),
      .nxt_item (nxt_k),
      .held     (held[k]),
      .pass     (pass[k])
    );
  end

  assign head = held[0];
  assign drop = pass[DEPTH-1].valid;

endmodule
`default_nettype wire
